// ===== hw/rtl/hnst_pkg.sv =====
package hnst_pkg;

	// defaults for the top-level parameters
	localparam int SLOTS_DEF       = 64;
	localparam int HANDLE_BITS_DEF = 16;

	// fixed field widths
	localparam int CFG_W    = 7;
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int HIN_W    = 16;
	localparam int STAT_W   = 2;
	localparam int SLOT_W   = 6;
	localparam int CNT_W    = 7;
	localparam int HASH_W   = 32;

	// remainder unit: bits of the hash retired per cycle
	localparam int DIV_STEP  = 4;
	localparam int DIV_ITERS = HASH_W / DIV_STEP;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);

	localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 7'd64;
	localparam logic [CNT_W-1:0] COUNT_MAX      = 7'd127;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] stat_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_DELETE = 2'd1;
	localparam op_t OP_LOOKUP = 2'd2;

	localparam stat_t STAT_OK    = 2'd0;
	localparam stat_t STAT_EMPTY = 2'd1;
	localparam stat_t STAT_FULL  = 2'd2;

endpackage

// ===== hw/rtl/hashed_name_slot_table.sv =====
// Hashed name slot table.
// A name arrives one item per byte on the input channel (in_valid/in_ready):
// op, name_byte, handle and last_byte. Every byte folds into a 32-bit hash as
// h = 17*h + byte. The item that carries last_byte selects the slot as hash
// modulo table_size and runs insert, delete or lookup on it; exactly one
// result item (status, found_handle, slot_index, entry_count) then leaves on
// the output channel (out_valid/out_ready). Other bytes give no result.
// A byte without last_byte only folds into the hash. A last byte passes first
// through the remainder unit, which retires four hash bits per cycle, then
// through a read of the slot memory and an update of it that also loads the
// output register. in_ready stays low meanwhile.
// Reset clears the hash, the entry count and out_valid, sets table_size to 64
// and sweeps the slot memory empty, one entry a cycle, so in_ready rises only
// once the sweep is done. A stalled receiver holds the result in the output
// register; further bytes are still taken, and a following last byte waits
// for the register to drain. The user must write table_size through
// cfg_we/cfg_wdata only while the block is idle; the block does not check it.
module hashed_name_slot_table
	import hnst_pkg::*;
#(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic signed [BYTE_W-1:0] name_byte,
	input  logic              last_byte,
	input  logic [HIN_W-1:0]  handle,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [HIN_W-1:0]  found_handle,
	output logic [SLOT_W-1:0] slot_index,
	output logic [CNT_W-1:0]  entry_count
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int ENT_W = HANDLE_BITS + 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_EXEC  = 3'd4;

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       clr_q;
	logic [CFG_W-1:0]       table_size_q;
	logic [HASH_W-1:0]      hash_q;
	logic [HASH_W-1:0]      hash_nxt;
	logic [HASH_W-1:0]      div_q;
	logic [CFG_W-1:0]       rem_q;
	logic [CFG_W-1:0]       rem_nxt;
	logic [DIV_CNT_W-1:0]   iter_q;
	op_t                    op_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [CNT_W-1:0]       count_q;
	logic [CFG_W-1:0]       eff_size;
	logic                   accept;
	logic                   out_free;
	logic                   exec_go;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENT_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [ENT_W-1:0]       ram_rdata;
	logic                   ent_valid;
	logic [HANDLE_BITS-1:0] ent_handle;

	stat_t                  stat_nxt;
	logic [HIN_W-1:0]       found_nxt;
	logic [CNT_W-1:0]       count_nxt;

	logic                   out_valid_q;
	stat_t                  status_q;
	logic [HIN_W-1:0]       found_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       entry_q;

	// a size of zero acts as one, a size beyond the table as the whole table
	always_comb begin
		if (table_size_q == '0) begin
			eff_size = CFG_W'(1);
		end else if (32'(table_size_q) > SLOTS) begin
			eff_size = CFG_W'(SLOTS);
		end else begin
			eff_size = table_size_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign exec_go  = (state_q == S_EXEC) && out_free;

	// 17*h as a shift and add, byte sign-extended
	assign hash_nxt = (hash_q << 4) + hash_q + HASH_W'(name_byte);

	// restoring remainder, four dependent bit steps per cycle
	always_comb begin
		logic [CFG_W:0] t;
		logic [CFG_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < DIV_STEP; k++) begin
			t = {r, div_q[HASH_W-1-k]};
			if (t >= {1'b0, eff_size}) begin
				t = t - {1'b0, eff_size};
			end
			r = t[CFG_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			hash_q  <= '0;
			iter_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (last_byte) begin
							hash_q  <= '0;
							iter_q  <= '0;
							state_q <= S_DIV;
						end else begin
							hash_q <= hash_nxt;
						end
					end
				end
				S_DIV: begin
					iter_q <= iter_q + DIV_CNT_W'(1);
					if (iter_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operands of the pending operation
	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			div_q    <= hash_nxt;
			rem_q    <= '0;
			op_q     <= op;
			handle_q <= HANDLE_BITS'(handle);
		end else if (state_q == S_DIV) begin
			div_q <= div_q << DIV_STEP;
			rem_q <= rem_nxt;
		end
	end

	assign ent_valid  = ram_rdata[HANDLE_BITS];
	assign ent_handle = ram_rdata[HANDLE_BITS-1:0];

	// decide the operation on the entry read back, or clear a slot during the sweep
	always_comb begin
		stat_nxt  = STAT_OK;
		found_nxt = '0;
		count_nxt = count_q;
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(rem_q);
		ram_wdata = {1'b0, handle_q};
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_EXEC: begin
				case (op_q)
					OP_INSERT: begin
						if (count_q >= eff_size) begin
							stat_nxt = STAT_FULL;
						end else begin
							ram_we    = exec_go;
							ram_wdata = {1'b1, handle_q};
							if (count_q != COUNT_MAX) begin
								count_nxt = count_q + CNT_W'(1);
							end
						end
					end
					OP_DELETE: begin
						if (ent_valid) begin
							ram_we    = exec_go;
							ram_wdata = {1'b0, ent_handle};
							if (count_q != '0) begin
								count_nxt = count_q - CNT_W'(1);
							end
						end else begin
							stat_nxt = STAT_EMPTY;
						end
					end
					OP_LOOKUP: begin
						if (ent_valid) begin
							found_nxt = HIN_W'(ent_handle);
						end else begin
							stat_nxt = STAT_EMPTY;
						end
					end
					default: begin
						stat_nxt = STAT_OK;
					end
				endcase
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re = (state_q == S_READ);

	hnst_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (IDX_W'(rem_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register: load only once the previous item has left
	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q <= stat_nxt;
			found_q  <= found_nxt;
			slot_q   <= SLOT_W'(rem_q);
			entry_q  <= count_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_handle = found_q;
	assign slot_index   = slot_q;
	assign entry_count  = entry_q;

endmodule

// ===== hw/rtl/hnst_ram.sv =====
module hnst_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/hnst_chk.sv =====
module hnst_chk
	import hnst_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic [HIN_W-1:0]  found_handle,
	input logic [CNT_W-1:0]  entry_count
);

	// a stalled result holds out_valid, status, found_handle and entry_count
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(found_handle) && $stable(entry_count))
		else $error("result changed while stalled");

	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_EMPTY
			|| status == STAT_FULL))
		else $error("undefined status");

	a_fail_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_EMPTY || status == STAT_FULL)
			|-> found_handle == '0)
		else $error("handle returned on a failed operation");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> entry_count != '0)
		else $error("table full with no entries");

endmodule

bind hashed_name_slot_table hnst_chk u_hnst_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.found_handle (found_handle),
	.entry_count  (entry_count)
);
